// ----- design/wmf_pkg.sv -----
// Package for the 3x3 weighted mean filter: register map, controller state
// encoding and the command/status structs. No dependencies.
package wmf_pkg;

    localparam int CFG_ADDR_W = 5;

    // register byte addresses
    localparam logic [CFG_ADDR_W-1:0] ADDR_WIDTH  = 5'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_HEIGHT = 5'd4;
    localparam logic [CFG_ADDR_W-1:0] ADDR_KTOP   = 5'd8;
    localparam logic [CFG_ADDR_W-1:0] ADDR_KMID   = 5'd12;
    localparam logic [CFG_ADDR_W-1:0] ADDR_KBOT   = 5'd16;

    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [10:0] HEIGHT_RESET = 11'd1024;
    localparam logic [23:0] KTOP_RESET   = 24'h000100;
    localparam logic [23:0] KMID_RESET   = 24'h010401;
    localparam logic [23:0] KBOT_RESET   = 24'h000100;

    // weighted sum: 9 * 255 * 255 < 2^20; weight sum: 9 * 255 < 2^12
    localparam int ACC_W  = 20;
    localparam int WSUM_W = 12;
    localparam int QUO_W  = 9;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_MAC    = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_EMIT   = 6'b010000,
        ST_FINISH = 6'b100000
    } wmf_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // latch the new pixel, start line store read
        logic shift;      // write line stores, shift the window
        logic mac_start;  // clear the accumulators
        logic mac_step;   // add one window row
        logic div_start;  // load the divider
        logic div_step;   // one quotient bit
        logic advance;    // move to the next pixel position
    } wmf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic has_result; // position has a full window
        logic mac_done;
        logic div_done;
    } wmf_status_t;

endpackage

// ----- design/wmf_stream_if.sv -----
// Valid/ready stream interfaces for pixels in and filtered results out.
// No dependencies.
interface wmf_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface wmf_result_if;
    logic       valid;
    logic       ready;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic [7:0] value;
    logic       last;
    modport source (output valid, output out_row, output out_col, output value,
                    output last, input ready);
    modport sink (input valid, input out_row, input out_col, input value,
                  input last, output ready);
endinterface

// ----- design/weighted_mean_filter_3x3.sv -----
// Top level of the 3x3 weighted mean filter.
// Depends on wmf_pkg, wmf_stream_if, wmf_regs, wmf_ctrl and wmf_datapath.

// Streaming 3x3 weighted mean filter for 8-bit grey pixels in raster order.
// Each pixel item is read, then run through the three-step row-wise
// multiply-accumulate; when it yields n results (1 to 4), the 22-step
// bit-serial divider follows and the results are emitted, held by output
// stall. Border pixels repeat their inner neighbor's value; results carry
// their row and column, and last marks the final result of each pixel.
// Registers (APB, byte addresses): 0 width, 4 height, 8/12/16 kernel rows
// top/middle/bottom, three 8-bit weights each, left weight in the low byte.
// Configure only while idle; line stores need no clearing after reset.
module weighted_mean_filter_3x3
    import wmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    wmf_pixel_if.sink             pixels,
    wmf_result_if.source          results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic [10:0] width_reg, height_reg;
    logic [23:0] ktop_reg, kmid_reg, kbot_reg;
    wmf_cmd_t    cmd;
    wmf_status_t status;
    logic        emit_start, emit_next, emit_last;

    assign pready       = 1'b1;
    assign results.last = emit_last;

    wmf_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .width_reg(width_reg), .height_reg(height_reg),
        .ktop_reg(ktop_reg), .kmid_reg(kmid_reg), .kbot_reg(kbot_reg));

    wmf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pixels.valid), .in_ready(pixels.ready),
        .out_valid(results.valid), .out_ready(results.ready),
        .emit_last(emit_last), .status(status), .cmd(cmd),
        .emit_start(emit_start), .emit_next(emit_next));

    wmf_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .emit_start(emit_start), .emit_next(emit_next), .emit_last(emit_last),
        .pixel(pixels.pixel), .width_cfg(width_reg), .height_cfg(height_reg),
        .ktop(ktop_reg), .kmid(kmid_reg), .kbot(kbot_reg),
        .out_row(results.out_row), .out_col(results.out_col),
        .value(results.value));
endmodule

// ----- design/wmf_ram.sv -----
// Generic single-port RAM with registered read (read-before-write).
// No dependencies.
module wmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[addr];
        end
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end
endmodule

// ----- design/wmf_regs.sv -----
// APB register file of the filter: sizes and kernel weights.
// Depends on wmf_pkg.
module wmf_regs
    import wmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic [10:0]           width_reg,
    output logic [10:0]           height_reg,
    output logic [23:0]           ktop_reg,
    output logic [23:0]           kmid_reg,
    output logic [23:0]           kbot_reg
);
    logic wr;
    assign wr = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            ktop_reg   <= KTOP_RESET;
            kmid_reg   <= KMID_RESET;
            kbot_reg   <= KBOT_RESET;
        end
        else if (wr)
        begin
            case (paddr)
                ADDR_WIDTH:  width_reg  <= pwdata[10:0];
                ADDR_HEIGHT: height_reg <= pwdata[10:0];
                ADDR_KTOP:   ktop_reg   <= pwdata[23:0];
                ADDR_KMID:   kmid_reg   <= pwdata[23:0];
                ADDR_KBOT:   kbot_reg   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (paddr)
            ADDR_WIDTH:  prdata = {21'd0, width_reg};
            ADDR_HEIGHT: prdata = {21'd0, height_reg};
            ADDR_KTOP:   prdata = {8'd0, ktop_reg};
            ADDR_KMID:   prdata = {8'd0, kmid_reg};
            ADDR_KBOT:   prdata = {8'd0, kbot_reg};
            default:     prdata = 32'd0;
        endcase
    end
endmodule

// ----- design/wmf_ctrl.sv -----
// Controller of the filter: sequences read, row-wise MAC, divide and the
// emission of up to four results for each pixel. Depends on wmf_pkg.
module wmf_ctrl
    import wmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  logic        emit_last,
    input  wmf_status_t status,
    output wmf_cmd_t    cmd,
    output logic        emit_start,
    output logic        emit_next
);
    wmf_state_t state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        emit_start = 1'b0;
        emit_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.shift = 1'b1;
                cmd.mac_start = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (status.mac_done)
                begin
                    if (status.has_result)
                    begin
                        cmd.div_start = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    emit_start = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    emit_next = 1'b1;
                    if (emit_last)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                cmd.advance = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ----- design/wmf_datapath.sv -----
// Datapath of the filter: line stores, window, position counters, row-wise
// MAC, restoring divider and result list. Depends on wmf_pkg and wmf_ram.
module wmf_datapath
    import wmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  wmf_cmd_t    cmd,
    output wmf_status_t status,
    input  logic        emit_start,
    input  logic        emit_next,
    output logic        emit_last,
    input  logic [7:0]  pixel,
    input  logic [10:0] width_cfg,
    input  logic [10:0] height_cfg,
    input  logic [23:0] ktop,
    input  logic [23:0] kmid,
    input  logic [23:0] kbot,
    output logic [9:0]  out_row,
    output logic [9:0]  out_col,
    output logic [7:0]  value
);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int SZW = (CW > RW ? CW : RW) > 11 ? (CW > RW ? CW : RW) : 11;
    localparam int DW  = ACC_W + 2;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [7:0]    px_reg;
    logic [7:0]    win_reg [3][3];
    logic [7:0]    up_rd, lo_rd;

    // effective frame size, clamped
    logic [SZW-1:0] wcfg, hcfg, wmax, hmax;
    logic [CW-1:0]  w_eff;
    logic [RW-1:0]  h_eff;
    assign wcfg = SZW'(width_cfg);
    assign hcfg = SZW'(height_cfg);
    assign wmax = SZW'(MAX_WIDTH);
    assign hmax = SZW'(MAX_HEIGHT);
    always_comb
    begin
        if (wcfg < SZW'(3))    w_eff = CW'(3);
        else if (wcfg > wmax)  w_eff = CW'(MAX_WIDTH);
        else                   w_eff = CW'(wcfg);
        if (hcfg < SZW'(3))    h_eff = RW'(3);
        else if (hcfg > hmax)  h_eff = RW'(MAX_HEIGHT);
        else                   h_eff = RW'(hcfg);
    end

    logic col_ok;
    assign col_ok = (col_reg < CW'(MAX_WIDTH));

    // line stores: read on accept, write back on shift
    wmf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
        .clk(clk), .we(cmd.shift && col_ok), .re(cmd.accept),
        .addr(col_reg[AW-1:0]), .wdata(lo_rd), .rdata(up_rd));
    wmf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_lower (
        .clk(clk), .we(cmd.shift && col_ok), .re(cmd.accept),
        .addr(col_reg[AW-1:0]), .wdata(px_reg), .rdata(lo_rd));

    logic [7:0] up_v, lo_v;
    assign up_v = col_ok ? up_rd : 8'd0;
    assign lo_v = col_ok ? lo_rd : 8'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg <= pixel;
        end
    end

    // window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= 8'd0;
                end
            end
        end
        else if (cmd.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= up_v;
            win_reg[1][2] <= lo_v;
            win_reg[2][2] <= px_reg;
        end
    end

    // MAC over one window row per cycle
    logic [1:0]        mrow_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [WSUM_W-1:0] wsum_next;
    logic [23:0]       krow;
    logic [17:0]       rsum;
    logic [9:0]        rwsum;
    always_comb
    begin
        case (mrow_reg)
            2'd0:    krow = ktop;
            2'd1:    krow = kmid;
            default: krow = kbot;
        endcase
        rsum = 18'(krow[7:0] * win_reg[mrow_reg][0])
             + 18'(krow[15:8] * win_reg[mrow_reg][1])
             + 18'(krow[23:16] * win_reg[mrow_reg][2]);
        rwsum = 10'(krow[7:0]) + 10'(krow[15:8]) + 10'(krow[23:16]);
    end

    assign acc_next  = acc_reg + ACC_W'(rsum);
    assign wsum_next = wsum_reg + WSUM_W'(rwsum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mrow_reg <= 2'd0;
        end
        else if (cmd.mac_start)
        begin
            mrow_reg <= 2'd0;
        end
        else if (cmd.mac_step)
        begin
            mrow_reg <= (mrow_reg == 2'd2) ? 2'd0 : mrow_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_start)
        begin
            acc_reg  <= '0;
            wsum_reg <= '0;
        end
        else if (cmd.mac_step)
        begin
            acc_reg  <= acc_next;
            wsum_reg <= wsum_next;
        end
    end

    // restoring divide: (2*acc + wsum) / (2*wsum), one bit per cycle
    // loaded during the last MAC step, so it takes the sums with the bottom row
    localparam int DCW = $clog2(DW + 1);
    logic [DW-1:0]     num_reg;
    logic [DW-1:0]     rem_reg;
    logic [WSUM_W:0]   den_reg;
    logic [DCW-1:0]    dcnt_reg;
    logic [DW:0]       trial;
    assign trial = {rem_reg, num_reg[DW-1]} - (DW+1)'(den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= DCW'(DW);
        end
        else if (cmd.div_step && dcnt_reg != '0)
        begin
            dcnt_reg <= dcnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg <= {1'b0, acc_next, 1'b0} + DW'(wsum_next);
            rem_reg <= '0;
            den_reg <= {wsum_next, 1'b0};
        end
        else if (cmd.div_step && dcnt_reg != '0)
        begin
            if (!trial[DW])
            begin
                rem_reg <= trial[DW-1:0];
                num_reg <= {num_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DW-2:0], num_reg[DW-1]};
                num_reg <= {num_reg[DW-2:0], 1'b0};
            end
        end
    end

    // result list: rows and columns around the window center
    logic [1:0] ri_reg, ci_reg;
    logic [2:0] cnt_reg;
    logic       top_b, bot_b, lft_b, rgt_b;
    logic [1:0] nr, nc;
    assign top_b = (row_reg == RW'(2));
    assign bot_b = (row_reg == h_eff - RW'(1));
    assign lft_b = (col_reg == CW'(2));
    assign rgt_b = (col_reg == w_eff - CW'(1));
    assign nr = 2'd1 + 2'(top_b) + 2'(bot_b);
    assign nc = 2'd1 + 2'(lft_b) + 2'(rgt_b);

    logic [RW-1:0] row_sel;
    logic [CW-1:0] col_sel;
    always_comb
    begin
        if (top_b && ri_reg == 2'd0)
            row_sel = '0;
        else if (ri_reg == 2'(top_b))
            row_sel = row_reg - RW'(1);
        else
            row_sel = row_reg;
        if (lft_b && ci_reg == 2'd0)
            col_sel = '0;
        else if (ci_reg == 2'(lft_b))
            col_sel = col_reg - CW'(1);
        else
            col_sel = col_reg;
    end
    assign out_row = 10'(row_sel);
    assign out_col = 10'(col_sel);

    logic row_end;
    assign row_end   = (ci_reg == nc - 2'd1);
    assign emit_last = (cnt_reg == 3'd3) || (row_end && ri_reg == nr - 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ri_reg  <= '0;
            ci_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (emit_start)
        begin
            ri_reg  <= '0;
            ci_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (emit_next)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (row_end)
            begin
                ci_reg <= '0;
                ri_reg <= ri_reg + 2'd1;
            end
            else
            begin
                ci_reg <= ci_reg + 2'd1;
            end
        end
    end

    assign value = (wsum_reg == '0) ? 8'd0 : num_reg[7:0];

    // position counters
    logic [CW-1:0] col_inc;
    assign col_inc = col_reg + CW'(1);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.advance)
        begin
            if (col_inc >= w_eff)
            begin
                col_reg <= '0;
                row_reg <= (row_reg + RW'(1) >= h_eff) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_inc;
            end
        end
    end

    assign status.has_result = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
    assign status.mac_done   = (mrow_reg == 2'd2);
    assign status.div_done   = (dcnt_reg == DCW'(1));
endmodule
